// ----- rtl/core/lmr_pkg.sv -----
// Shared constants, codes and queue entry type of the learning message router.
`default_nettype none

package lmr_pkg;

    // Sizes
    localparam int CHANNELS      = 4;
    localparam int CH_W          = 2;
    localparam int ACNT_W        = 3;
    localparam int ROUTE_ENTRIES = 16;
    localparam int RT_IDX_W      = 4;
    localparam int RT_CNT_W      = 5;
    localparam int NODE_W        = 8;

    // Special node ids
    localparam logic [NODE_W-1:0] FREE_ID     = 8'hFF;
    localparam logic [NODE_W-1:0] FALLBACK_ID = 8'h01;

    // Request operations
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_SEND    = 1'b1;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_LOOPBACK  = 3'd0,
        ACT_LOCAL     = 3'd1,
        ACT_BROADCAST = 3'd2,
        ACT_FORWARD   = 3'd3,
        ACT_NO_ROUTE  = 3'd4
    } action_t;

    // Classified request passed from front to back
    typedef struct packed {
        logic                  need_lookup;
        logic                  do_learn;
        action_t               action;
        logic                  deliver;
        logic [CHANNELS-1:0]   mask;
        logic [NODE_W-1:0]     fwd_src;
        logic [NODE_W-1:0]     src;
        logic [CH_W-1:0]       ingress;
        logic [NODE_W-1:0]     tgt;
        logic [ACNT_W-1:0]     acnt;
    } lmr_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/lmr_ifs.sv -----
// Request and result channel interfaces of the learning message router.
`default_nettype none

interface lmr_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [1:0] ingress_channel;
    logic [7:0] source_node;
    logic [7:0] target_node;

    modport source (output valid, operation, ingress_channel, source_node, target_node,
                    input ready);
    modport sink (input valid, operation, ingress_channel, source_node, target_node,
                  output ready);
endinterface

interface lmr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       deliver_local;
    logic [3:0] egress_mask;
    logic [7:0] forward_source;
    logic       learn_failed;

    modport source (output valid, action, deliver_local, egress_mask, forward_source,
                    learn_failed, input ready);
    modport sink (input valid, action, deliver_local, egress_mask, forward_source,
                  learn_failed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/learning_message_router.sv -----
// Learning message router: one result per decoded message header.
// Requests arrive on req (operation, ingress_channel, source_node,
// target_node) and are accepted when req.valid and req.ready are high.
// Each request gives exactly one result on rsp (action, deliver_local,
// egress_mask, forward_source, learn_failed), taken when rsp.valid and
// rsp.ready are high. The front classifies a request in the accept cycle
// and queues it (two entries). The back handles each request in two steps:
// the route table learning write, then the lookup into the result
// register. It pops the next request only once the result of the last
// is loaded, so requests pass the learn-then-lookup sequence on the
// single route table one at a time.
// When rsp is stalled the result register holds, the back waits, and the
// queue keeps taking requests until it is full; then req.ready drops.
// Reset empties the queue, clears the route table (no entries in use),
// and sets local_node_id and active_channels to zero.
// Registers over APB: local_node_id at 0x0, active_channels at 0x4;
// write them only while no request is in flight.
`default_nettype none

module learning_message_router
    import lmr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    lmr_req_if.sink          req,
    lmr_rsp_if.source        rsp
);

    logic [NODE_W-1:0] local_id_reg;
    logic [ACNT_W-1:0] active_reg;
    lmr_entry_t        fe_entry;
    lmr_entry_t        head;
    logic              q_full;
    logic              head_valid;
    logic              pop;
    logic              cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= '0;
            active_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                active_reg <= pwdata[ACNT_W-1:0];
            else
                local_id_reg <= pwdata[NODE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2])
            prdata = {{(32-ACNT_W){1'b0}}, active_reg};
        else
            prdata = {{(32-NODE_W){1'b0}}, local_id_reg};
    end

    // Front end classification
    lmr_front u_front (
        .in_operation    (req.operation),
        .in_ingress      (req.ingress_channel),
        .in_src          (req.source_node),
        .in_tgt          (req.target_node),
        .local_id        (local_id_reg),
        .active_channels (active_reg),
        .entry           (fe_entry)
    );

    assign req.ready = !q_full;

    // Queue between front and back
    lmr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (req.valid && !q_full),
        .push_data  (fe_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: table and results
    lmr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lmr_front.sv -----
// Front end: classifies each incoming request against the local id and channel count.
`default_nettype none

module lmr_front
    import lmr_pkg::*;
(
    input  wire logic                 in_operation,
    input  wire logic [CH_W-1:0]      in_ingress,
    input  wire logic [NODE_W-1:0]    in_src,
    input  wire logic [NODE_W-1:0]    in_tgt,
    input  wire logic [NODE_W-1:0]    local_id,
    input  wire logic [ACNT_W-1:0]    active_channels,
    output lmr_entry_t                entry
);

    logic [ACNT_W-1:0]   acnt;
    logic [CHANNELS-1:0] amask;
    logic [CHANNELS-1:0] ingress_bit;

    // Clamp the active count and build the active channel mask
    always_comb
    begin
        if (active_channels > ACNT_W'(CHANNELS))
            acnt = ACNT_W'(CHANNELS);
        else
            acnt = active_channels;
        for (int c = 0; c < CHANNELS; c++)
            amask[c] = ACNT_W'(c) < acnt;
        ingress_bit = CHANNELS'(1) << in_ingress;
    end

    // Classification
    always_comb
    begin
        entry.need_lookup = 1'b0;
        entry.do_learn    = 1'b0;
        entry.action      = ACT_LOOPBACK;
        entry.deliver     = 1'b0;
        entry.mask        = '0;
        entry.fwd_src     = in_src;
        entry.src         = in_src;
        entry.ingress     = in_ingress;
        entry.tgt         = in_tgt;
        entry.acnt        = acnt;
        if (in_operation == OP_RECEIVE)
        begin
            if (in_src != local_id)
            begin
                entry.do_learn = (in_src != FREE_ID);
                if (in_tgt == local_id)
                begin
                    entry.action  = ACT_LOCAL;
                    entry.deliver = 1'b1;
                end
                else if (in_tgt == FREE_ID)
                begin
                    entry.action  = ACT_BROADCAST;
                    entry.deliver = 1'b1;
                    entry.mask    = amask & ~ingress_bit;
                end
                else
                begin
                    entry.need_lookup = 1'b1;
                end
            end
        end
        else
        begin
            entry.fwd_src = local_id;
            if (in_tgt == FREE_ID)
            begin
                entry.action = ACT_BROADCAST;
                entry.mask   = amask;
            end
            else
            begin
                entry.need_lookup = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lmr_fifo.sv -----
// Two-entry queue of classified requests between front and back.
`default_nettype none

module lmr_fifo
    import lmr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire lmr_entry_t  push_data,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output lmr_entry_t       head
);

    lmr_entry_t slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slots_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lmr_back.sv -----
// Back end: route table learning, target lookup and the result register.
`default_nettype none

module lmr_back
    import lmr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire lmr_entry_t  head,
    output logic             pop,
    lmr_rsp_if.source        rsp
);

    typedef enum logic [1:0] {
        ST_LEARN   = 2'b01,
        ST_RESOLVE = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    lmr_entry_t           cur_reg;
    logic                 fail_reg;

    // Route table: filled as a prefix, cnt_reg entries in use
    logic [NODE_W-1:0]    ids_reg   [ROUTE_ENTRIES];
    logic [CH_W-1:0]      chans_reg [ROUTE_ENTRIES];
    logic [RT_CNT_W-1:0]  cnt_reg, cnt_next;

    logic                 out_valid_reg;
    logic [2:0]           out_action_reg;
    logic                 out_deliver_reg;
    logic [CHANNELS-1:0]  out_mask_reg;
    logic [NODE_W-1:0]    out_fsrc_reg;
    logic                 out_fail_reg;

    logic                 learn_hit;
    logic [RT_IDX_W-1:0]  learn_idx;
    logic                 table_full;
    logic                 learn_fail;
    logic                 look_hit;
    logic [RT_IDX_W-1:0]  look_idx;
    logic [CH_W-1:0]      look_ch;
    action_t              res_action;
    logic [CHANNELS-1:0]  res_mask;
    logic                 out_free;
    logic                 load_out;

    assign out_free = !out_valid_reg || rsp.ready;
    assign pop      = (state_reg == ST_LEARN) && head_valid;
    assign load_out = (state_reg == ST_RESOLVE) && out_free;

    // Source match against the table (ids are unique, so OR the index)
    always_comb
    begin
        learn_hit = 1'b0;
        learn_idx = '0;
        for (int i = 0; i < ROUTE_ENTRIES; i++)
        begin
            if ((RT_CNT_W'(i) < cnt_reg) && (ids_reg[i] == head.src))
            begin
                learn_hit = 1'b1;
                learn_idx = learn_idx | RT_IDX_W'(i);
            end
        end
        table_full = (cnt_reg == RT_CNT_W'(ROUTE_ENTRIES));
        learn_fail = head.do_learn && !learn_hit && table_full;
        cnt_next   = cnt_reg;
        if (pop && head.do_learn && !learn_hit && !table_full)
            cnt_next = cnt_reg + RT_CNT_W'(1);
    end

    // Target lookup on the updated table
    always_comb
    begin
        look_hit = 1'b0;
        look_idx = '0;
        for (int i = 0; i < ROUTE_ENTRIES; i++)
        begin
            if ((RT_CNT_W'(i) < cnt_reg) && (ids_reg[i] == cur_reg.tgt))
            begin
                look_hit = 1'b1;
                look_idx = look_idx | RT_IDX_W'(i);
            end
        end
        look_ch    = chans_reg[look_idx];
        res_action = cur_reg.action;
        res_mask   = cur_reg.mask;
        if (cur_reg.need_lookup)
        begin
            res_action = ACT_NO_ROUTE;
            res_mask   = '0;
            if (look_hit)
            begin
                if (ACNT_W'(look_ch) < cur_reg.acnt)
                begin
                    res_action = ACT_FORWARD;
                    res_mask   = CHANNELS'(1) << look_ch;
                end
            end
            else if ((cur_reg.tgt == FALLBACK_ID) && (cur_reg.acnt != '0))
            begin
                res_action = ACT_FORWARD;
                res_mask   = CHANNELS'(1);
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LEARN:
            begin
                if (head_valid)
                    state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (out_free)
                    state_next = ST_LEARN;
            end
            default:
            begin
                state_next = ST_LEARN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LEARN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Table write and current request capture
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg  <= head;
            fail_reg <= learn_fail;
            if (head.do_learn)
            begin
                if (learn_hit)
                    chans_reg[learn_idx] <= head.ingress;
                else if (!table_full)
                begin
                    ids_reg[cnt_reg[RT_IDX_W-1:0]]   <= head.src;
                    chans_reg[cnt_reg[RT_IDX_W-1:0]] <= head.ingress;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_action_reg  <= res_action;
            out_deliver_reg <= cur_reg.deliver;
            out_mask_reg    <= res_mask;
            out_fsrc_reg    <= cur_reg.fwd_src;
            out_fail_reg    <= fail_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.action         = out_action_reg;
    assign rsp.deliver_local  = out_deliver_reg;
    assign rsp.egress_mask    = out_mask_reg;
    assign rsp.forward_source = out_fsrc_reg;
    assign rsp.learn_failed   = out_fail_reg;

endmodule

`default_nettype wire
